>>> hdl/lobm_pkg.sv
// shared types, constants and result codes for the order matcher
`default_nettype none
package lobm_pkg;
    localparam int SLOTS_DEF      = 32;
    localparam int PRICE_BITS_DEF = 16;
    localparam int QTY_BITS_DEF   = 20;
    localparam int ID_BITS        = 16;
    localparam int KIND_BITS      = 3;
    localparam int AGE_BITS       = 32;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_FILL      = 3'd0,
        KIND_RESTED    = 3'd1,
        KIND_FILLED    = 3'd2,
        KIND_REJECTED  = 3'd3,
        KIND_CANCELLED = 3'd4,
        KIND_NOT_FOUND = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_DECIDE,
        ST_OUT_WAIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the incoming item
        logic scan_start;  // clear search results, start at slot 0
        logic scan_step;   // evaluate current slot, advance
        logic do_fill;     // apply a fill to the best slot, emit fill result
        logic do_cancel;   // free the hit slot, emit cancel result
        logic do_final;    // rest or reject remainder, emit final result
        logic out_pop;     // output register taken
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_cancel;
        logic scan_done;
        logic found;
        logic qty_zero;
        logic out_full;
        logic fills_max;
    } dp_stat_t;
endpackage
`default_nettype wire

>>> hdl/lobm_stream_if.sv
// valid/ready channel carrying a packed payload
`default_nettype none
interface lobm_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/lobm_ctrl.sv
// controller state machine sequencing scans, fills and final results
`default_nettype none
module lobm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output lobm_pkg::dp_cmd_t       cmd,
    input  wire lobm_pkg::dp_stat_t stat,
    input  wire logic               out_ready
);
    import lobm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cmd.out_pop = stat.out_full && out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_start = 1'b1;
                state_next     = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (stat.scan_done)
                    state_next = ST_DECIDE;
                else
                    cmd.scan_step = 1'b1;
            end
            ST_DECIDE:
            begin
                // output register must be free, or taken in the same cycle, before a result is written
                if (!stat.out_full || out_ready)
                begin
                    if (stat.is_cancel)
                    begin
                        cmd.do_cancel = 1'b1;
                        state_next    = ST_OUT_WAIT;
                    end
                    else if (!stat.qty_zero && stat.found && !stat.fills_max)
                    begin
                        cmd.do_fill = 1'b1;
                        state_next  = ST_SCAN;
                    end
                    else
                    begin
                        cmd.do_final = 1'b1;
                        state_next   = ST_OUT_WAIT;
                    end
                end
            end
            ST_OUT_WAIT:
            begin
                in_ready = !stat.out_full || out_ready;
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
                else
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> hdl/lobm_dp.sv
// datapath: slot registers, serial best-slot search, fill arithmetic, output register
`default_nettype none
module lobm_dp #(
    parameter int SLOTS      = lobm_pkg::SLOTS_DEF,
    parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = lobm_pkg::QTY_BITS_DEF,
    localparam int IW = 1 + lobm_pkg::ID_BITS + 1 + PRICE_BITS + QTY_BITS,
    localparam int OW = lobm_pkg::KIND_BITS + 2*lobm_pkg::ID_BITS + 3*PRICE_BITS
                        + 2*QTY_BITS + 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [IW-1:0]       in_data,
    input  wire lobm_pkg::dp_cmd_t   cmd,
    output lobm_pkg::dp_stat_t       stat,
    output logic                     out_valid,
    output logic [OW-1:0]            out_data
);
    import lobm_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0]      valid_reg;
    logic [ID_BITS-1:0]    s_id_reg    [SLOTS];
    logic                  s_side_reg  [SLOTS];
    logic [PRICE_BITS-1:0] s_price_reg [SLOTS];
    logic [QTY_BITS-1:0]   s_qty_reg   [SLOTS];
    logic [AGE_BITS-1:0]   s_arr_reg   [SLOTS];
    logic [AGE_BITS-1:0]   arrival_reg;

    logic                  t_cmd_reg, t_side_reg;
    logic [ID_BITS-1:0]    t_id_reg;
    logic [PRICE_BITS-1:0] t_price_reg;
    logic [QTY_BITS-1:0]   t_qty_reg;

    logic [CW-1:0]         idx_reg;
    logic                  found_reg;
    logic [SW-1:0]         best_reg;
    logic [CW-1:0]         fills_reg;
    logic                  free_found_reg;
    logic [SW-1:0]         free_reg;

    logic                  oval_reg;
    logic [OW-1:0]         odata_reg;

    logic [SW-1:0]         cur;
    logic                  cand, better, crosses;
    logic [AGE_BITS-1:0]   age_cur, age_best;
    logic [QTY_BITS-1:0]   fill_q, m_qty;
    logic [KIND_BITS-1:0]  kind_v;

    assign cur      = idx_reg[SW-1:0];
    assign age_cur  = arrival_reg - s_arr_reg[cur];
    assign age_best = arrival_reg - s_arr_reg[best_reg];
    assign crosses  = t_side_reg ? (s_price_reg[cur] >= t_price_reg)
                                 : (s_price_reg[cur] <= t_price_reg);

    always_comb
    begin
        if (t_cmd_reg)
            cand = valid_reg[cur] && (s_id_reg[cur] == t_id_reg);
        else
            cand = valid_reg[cur] && (s_side_reg[cur] != t_side_reg) && crosses;
        if (!found_reg)
            better = 1'b1;
        else if (!t_cmd_reg && s_price_reg[cur] != s_price_reg[best_reg])
            better = t_side_reg ? (s_price_reg[cur] > s_price_reg[best_reg])
                                : (s_price_reg[cur] < s_price_reg[best_reg]);
        else
            better = age_cur > age_best;
    end

    assign m_qty  = s_qty_reg[best_reg];
    assign fill_q = (m_qty < t_qty_reg) ? m_qty : t_qty_reg;

    assign stat.is_cancel = t_cmd_reg;
    assign stat.scan_done = (idx_reg == CW'(SLOTS));
    assign stat.found     = found_reg;
    assign stat.qty_zero  = (t_qty_reg == '0);
    assign stat.out_full  = oval_reg;
    assign stat.fills_max = (fills_reg == CW'(SLOTS));

    always_comb
    begin
        priority if (!t_qty_reg[0] && t_qty_reg == '0)
            kind_v = KIND_FILLED;
        else if (!free_found_reg)
            kind_v = KIND_REJECTED;
        else
            kind_v = KIND_RESTED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            arrival_reg <= '0;
            oval_reg    <= 1'b0;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            fills_reg   <= '0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_fill || cmd.do_cancel || cmd.do_final)
                oval_reg <= 1'b1;
            else if (cmd.out_pop)
                oval_reg <= 1'b0;
            if (cmd.load)
                fills_reg <= '0;
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (cand && better)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= cur;
                end
                // lowest free slot
                if (!valid_reg[cur] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_reg       <= cur;
                end
            end
            if (cmd.do_fill)
            begin
                fills_reg <= fills_reg + 1'b1;
                s_qty_reg[best_reg] <= m_qty - fill_q;
                if (m_qty == fill_q)
                    valid_reg[best_reg] <= 1'b0;
                odata_reg <= {KIND_FILL, t_id_reg, s_id_reg[best_reg], t_price_reg,
                              fill_q,
                              t_side_reg ? t_price_reg : s_price_reg[best_reg],
                              t_side_reg ? s_price_reg[best_reg] : t_price_reg,
                              QTY_BITS'(t_qty_reg - fill_q), 1'b0};
            end
            if (cmd.do_cancel)
            begin
                if (found_reg)
                begin
                    valid_reg[best_reg] <= 1'b0;
                    odata_reg <= {KIND_CANCELLED, t_id_reg, ID_BITS'(0),
                                  s_price_reg[best_reg], QTY_BITS'(0),
                                  PRICE_BITS'(0), PRICE_BITS'(0),
                                  s_qty_reg[best_reg], 1'b1};
                end
                else
                    odata_reg <= {KIND_NOT_FOUND, t_id_reg, ID_BITS'(0),
                                  PRICE_BITS'(0), QTY_BITS'(0), PRICE_BITS'(0),
                                  PRICE_BITS'(0), QTY_BITS'(0), 1'b1};
            end
            if (cmd.do_final)
            begin
                odata_reg <= {kind_v, t_id_reg, ID_BITS'(0), t_price_reg,
                              QTY_BITS'(0), PRICE_BITS'(0), PRICE_BITS'(0),
                              t_qty_reg, 1'b1};
                if (kind_v == KIND_RESTED)
                begin
                    valid_reg[free_reg]   <= 1'b1;
                    s_id_reg[free_reg]    <= t_id_reg;
                    s_side_reg[free_reg]  <= t_side_reg;
                    s_price_reg[free_reg] <= t_price_reg;
                    s_qty_reg[free_reg]   <= t_qty_reg;
                    s_arr_reg[free_reg]   <= arrival_reg;
                    arrival_reg           <= arrival_reg + 1'b1;
                end
            end
        end
    end

    // item and remainder registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            {t_cmd_reg, t_id_reg, t_side_reg, t_price_reg, t_qty_reg} <= in_data;
        else if (cmd.do_fill)
            t_qty_reg <= t_qty_reg - fill_q;
    end

    assign out_valid = oval_reg;
    assign out_data  = odata_reg;
endmodule
`default_nettype wire

>>> hdl/limit_order_book_matcher.sv
// top level of the limit order matcher
`default_nettype none
// Price-time priority matcher over SLOTS resting slots. A new order is matched
// against the best crossing opposite slot repeatedly, emitting one fill result
// per trade and then a final result (rested, fully filled, or rejected when no
// slot is free); a cancel emits one result. Every search walks all slots one
// per cycle. One item is in work at a time; results leave through a single
// output register and the last result of an item has last set.
module limit_order_book_matcher #(
    parameter int SLOTS      = lobm_pkg::SLOTS_DEF,
    parameter int PRICE_BITS = lobm_pkg::PRICE_BITS_DEF,
    parameter int QTY_BITS   = lobm_pkg::QTY_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    lobm_stream_if.sink   in_ch,
    lobm_stream_if.source out_ch
);
    import lobm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lobm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ch.ready)
    );

    lobm_dp #(
        .SLOTS      (SLOTS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_ch.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_ch.valid),
        .out_data  (out_ch.data)
    );

    // at most one result write per cycle
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.do_fill, cmd.do_cancel, cmd.do_final}))
        else $error("several result writes in one cycle");

    // a result is never written over one not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_fill || cmd.do_cancel || cmd.do_final) && out_ch.valid |-> out_ch.ready)
        else $error("result overwritten");

    // no item taken while a search runs
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step || cmd.scan_start) |-> !in_ch.ready)
        else $error("input accepted during search");
endmodule
`default_nettype wire

>>> test/tb_limit_order_book_matcher.sv
// self-checking testbench for the limit order matcher: random traffic with a built-in book model
`timescale 1ns / 1ps
module tb_limit_order_book_matcher;
    import lobm_pkg::*;

    localparam int NSLOT      = 32;
    localparam int IDLE_LIMIT = 5000;

    localparam logic CMD_NEW    = 1'b0;
    localparam logic CMD_CANCEL = 1'b1;
    localparam logic SIDE_BUY   = 1'b0;
    localparam logic SIDE_SELL  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] ord_id;
        logic        side;
        logic [15:0] price;
        logic [19:0] quantity;
    } order_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] taker_id;
        logic [15:0] maker_id;
        logic [15:0] taker_price;
        logic [19:0] fill_quantity;
        logic [15:0] sell_px;
        logic [15:0] buy_px;
        logic [19:0] remaining_quantity;
        logic        last;
    } book_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lobm_stream_if #(.WIDTH($bits(order_item_t)))  in_ch();
    lobm_stream_if #(.WIDTH($bits(book_result_t))) out_ch();

    limit_order_book_matcher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #5 clk = ~clk;

    // book model
    logic        bk_valid   [NSLOT];
    logic [15:0] bk_id      [NSLOT];
    logic        bk_side    [NSLOT];
    logic [15:0] bk_price   [NSLOT];
    logic [19:0] bk_qty     [NSLOT];
    logic [31:0] bk_arrival [NSLOT];
    logic [31:0] arrival_count;

    order_item_t  pending_orders[$];
    book_result_t expected_results[$];

    int errors = 0;
    int orders_taken = 0;
    int results_seen = 0;
    int fills_seen = 0;
    int rejects_seen = 0;
    int idle_cycles = 0;
    int gap_left = 0;
    bit no_gaps = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] age(int s);
        return arrival_count - bk_arrival[s];
    endfunction

    task automatic add_result(kind_t k, logic [15:0] taker, logic [15:0] maker,
                              logic [15:0] tprice, logic [19:0] fill, logic [15:0] ask,
                              logic [15:0] bid, logic [19:0] rem, logic last);
        book_result_t r;
        r.kind = k;  r.taker_id = taker;  r.maker_id = maker;  r.taker_price = tprice;
        r.fill_quantity = fill;  r.sell_px = ask;  r.buy_px = bid;
        r.remaining_quantity = rem;  r.last = last;
        expected_results = {expected_results, r};
    endtask

    task automatic apply_item(order_item_t it);
        int hit;
        int best;
        int nfill;
        int freeslot;
        logic [19:0] qty;
        logic [19:0] f;
        bit better;
        if (it.cmd == CMD_CANCEL) begin
            hit = -1;
            for (int s = 0; s < NSLOT; s++)
                if (bk_valid[s] && bk_id[s] == it.ord_id && (hit < 0 || age(s) > age(hit)))
                    hit = s;
            if (hit < 0)
                add_result(KIND_NOT_FOUND, it.ord_id, '0, '0, '0, '0, '0, '0, 1'b1);
            else begin
                bk_valid[hit] = 1'b0;
                add_result(KIND_CANCELLED, it.ord_id, '0, bk_price[hit], '0, '0, '0,
                           bk_qty[hit], 1'b1);
            end
            return;
        end
        qty = it.quantity;
        nfill = 0;
        while (qty != 0 && nfill < NSLOT) begin
            best = -1;
            for (int s = 0; s < NSLOT; s++) begin
                if (!bk_valid[s] || bk_side[s] == it.side) continue;
                if (it.side == SIDE_BUY ? bk_price[s] > it.price : bk_price[s] < it.price)
                    continue;
                if (best < 0) better = 1;
                else if (bk_price[s] != bk_price[best])
                    better = (it.side == SIDE_BUY) ? bk_price[s] < bk_price[best]
                                                   : bk_price[s] > bk_price[best];
                else better = age(s) > age(best);
                if (better) best = s;
            end
            if (best < 0) break;
            f = bk_qty[best] < qty ? bk_qty[best] : qty;
            bk_qty[best] -= f;
            qty -= f;
            if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
            add_result(KIND_FILL, it.ord_id, bk_id[best], it.price, f,
                       it.side == SIDE_BUY ? bk_price[best] : it.price,
                       it.side == SIDE_BUY ? it.price : bk_price[best], qty, 1'b0);
            nfill++;
        end
        if (qty == 0) begin
            add_result(KIND_FILLED, it.ord_id, '0, it.price, '0, '0, '0, '0, 1'b1);
            return;
        end
        freeslot = -1;
        for (int s = NSLOT - 1; s >= 0; s--)
            if (!bk_valid[s]) freeslot = s;
        if (freeslot < 0) begin
            add_result(KIND_REJECTED, it.ord_id, '0, it.price, '0, '0, '0, qty, 1'b1);
            return;
        end
        bk_valid[freeslot] = 1'b1;
        bk_id[freeslot] = it.ord_id;
        bk_side[freeslot] = it.side;
        bk_price[freeslot] = it.price;
        bk_qty[freeslot] = qty;
        bk_arrival[freeslot] = arrival_count;
        arrival_count += 1;
        add_result(KIND_RESTED, it.ord_id, '0, it.price, '0, '0, '0, qty, 1'b1);
    endtask

    task automatic push_new(logic [15:0] id, logic side, logic [15:0] price,
                            logic [19:0] qty);
        order_item_t it;
        it.cmd = CMD_NEW;  it.ord_id = id;  it.side = side;
        it.price = price;  it.quantity = qty;
        pending_orders = {pending_orders, it};
    endtask

    task automatic push_cancel(logic [15:0] id);
        order_item_t it;
        it.cmd = CMD_CANCEL;  it.ord_id = id;
        it.side = 1'($urandom_range(0, 1));  it.price = 16'($urandom);
        it.quantity = 20'($urandom);
        pending_orders = {pending_orders, it};
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
        if (exp !== got) begin
            $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, exp, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        bit present;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else begin
            present = in_ch.valid;
            if (in_ch.valid && in_ch.ready) begin
                apply_item(pending_orders[0]);
                pending_orders.delete(0);
                orders_taken++;
                present = 0;
            end
            if (!present) begin
                if (gap_left > 0) gap_left--;
                else if (pending_orders.size() > 0) begin
                    present = 1;
                    gap_left = pick_gap();
                end
            end
            in_ch.valid <= present;
            in_ch.data  <= (pending_orders.size() > 0) ? pending_orders[0] : '0;
        end
    end

    // monitor and result checker
    always @(posedge clk or negedge rst_n) begin
        book_result_t got;
        book_result_t exp;
        if (!rst_n) out_ch.ready <= 1'b0;
        else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                results_seen++;
                if (got.kind == KIND_FILL) fills_seen++;
                if (got.kind == KIND_REJECTED) rejects_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %0h", $time, got);
                    errors++;
                end else begin
                    exp = expected_results[0];
                    expected_results.delete(0);
                    check_field("kind", 32'(exp.kind), 32'(got.kind));
                    check_field("taker_id", 32'(exp.taker_id), 32'(got.taker_id));
                    check_field("maker_id", 32'(exp.maker_id), 32'(got.maker_id));
                    check_field("taker_price", 32'(exp.taker_price), 32'(got.taker_price));
                    check_field("fill_quantity", 32'(exp.fill_quantity),
                                32'(got.fill_quantity));
                    check_field("sell_px", 32'(exp.sell_px), 32'(got.sell_px));
                    check_field("buy_px", 32'(exp.buy_px), 32'(got.buy_px));
                    check_field("remaining_quantity", 32'(exp.remaining_quantity),
                                32'(got.remaining_quantity));
                    check_field("last", 32'(exp.last), 32'(got.last));
                end
            end
            out_ch.ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) < 70 ? 1'b1
                           : ($urandom_range(0, 9) == 0 ? 1'b0
                                                        : 1'($urandom_range(0, 1))));
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int r;
        for (int s = 0; s < NSLOT; s++) bk_valid[s] = 1'b0;
        arrival_count = '0;

        // directed: not found, zero quantity, extremes, time priority, duplicate ids
        push_cancel(16'hFFFF);
        push_new(16'h1234, SIDE_BUY, 16'd500, 20'd0);
        push_new(16'h0000, SIDE_BUY, 16'hFFFF, 20'hFFFFF);
        push_new(16'hFFFF, SIDE_SELL, 16'h0000, 20'd5);
        push_cancel(16'h0000);
        push_new(16'd10, SIDE_BUY, 16'd100, 20'd10);
        push_new(16'd11, SIDE_BUY, 16'd100, 20'd10);
        push_new(16'd10, SIDE_BUY, 16'd101, 20'd3);
        push_cancel(16'd10);
        push_new(16'd20, SIDE_SELL, 16'd99, 20'd20);
        push_new(16'd21, SIDE_BUY, 16'hFFFF, 20'd7);
        push_new(16'd22, SIDE_SELL, 16'd0, 20'd0);
        push_cancel(16'd10);
        push_cancel(16'd10);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // flood the book on one side, then one sell sweeps every slot
        for (int i = 0; i < 36; i++)
            push_new(16'(100 + i), SIDE_BUY, 16'(900 + (i % 5)),
                     20'($urandom_range(1, 50)));
        push_new(16'd300, SIDE_SELL, 16'd0, 20'hFFFFF);
        push_cancel(16'd300);

        // random traffic around a narrow price band
        for (int i = 0; i < 70; i++) begin
            r = $urandom_range(0, 99);
            if (i % 30 == 0) begin
                while (pending_orders.size() >= 5) @(posedge clk);
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            if (r < 20)
                push_cancel(r < 3 ? 16'($urandom) : 16'($urandom_range(1, 40)));
            else
                push_new(r < 28 ? 16'($urandom) : 16'($urandom_range(1, 40)),
                         1'($urandom_range(0, 1)),
                         r < 32 ? 16'($urandom) : 16'($urandom_range(992, 1008)),
                         r < 34 ? 20'($urandom) : (r < 37 ? 20'd0
                                                 : 20'($urandom_range(1, 100))));
        end

        while (pending_orders.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d orders and cancels driven, %0d results checked", orders_taken,
                 results_seen);
        $display("%0d fills and %0d book-full rejects seen", fills_seen, rejects_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
